@@ rtl/hdg_pkg.sv @@
package hdg_pkg;

    localparam int TABLE_LEN     = 24;
    localparam int PRESCALE_BITS = 20;
    localparam int ACC_W         = 26;
    localparam int OUT_W         = 17;

    localparam logic signed [ACC_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] DEG360 = 26'sd23592960;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 26'sd128;

    localparam logic [OUT_W-1:0] FULL_TURN_OUT = 17'd92160;
    localparam logic [OUT_W-1:0] HALF_TURN_OUT = 17'd46080;
    localparam logic [OUT_W-1:0] ZERO_TURN_OUT = 17'd0;

    // Arctangent of 2^-i in degrees, scaled by 65536 and rounded to nearest.
    localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef struct packed {
        logic zero_dx;
        logic dz_pos;
        logic left_half;
    } hdg_flags_t;

endpackage

@@ rtl/hdg_cordic_stage.sv @@
module hdg_cordic_stage #(
    parameter int W     = 48,
    parameter int SHIFT = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [W-1:0]                 in_x,
    input  logic signed [W-1:0]                 in_y,
    input  logic signed [hdg_pkg::ACC_W-1:0]    in_acc,
    input  hdg_pkg::hdg_flags_t                 in_flags,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [W-1:0]                 out_x,
    output logic signed [W-1:0]                 out_y,
    output logic signed [hdg_pkg::ACC_W-1:0]    out_acc,
    output hdg_pkg::hdg_flags_t                 out_flags
);
    import hdg_pkg::*;

    logic                    valid_reg;
    logic signed [W-1:0]     x_reg;
    logic signed [W-1:0]     y_reg;
    logic signed [ACC_W-1:0] acc_reg;
    hdg_flags_t              flags_reg;

    logic signed [W-1:0]     x_next;
    logic signed [W-1:0]     y_next;
    logic signed [ACC_W-1:0] acc_next;

    always_comb begin
        if (in_y >= 0) begin
            x_next   = in_x + (in_y >>> SHIFT);
            y_next   = in_y - (in_x >>> SHIFT);
            acc_next = in_acc + ATAN_TAB[SHIFT];
        end else begin
            x_next   = in_x - (in_y >>> SHIFT);
            y_next   = in_y + (in_x >>> SHIFT);
            acc_next = in_acc - ATAN_TAB[SHIFT];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_flags = flags_reg;

endmodule

@@ rtl/heading_angle_degrees.sv @@
// Stages in order: difference, fold and prescale, CORDIC chain, output registers.
// One item per cycle unless stalled; each stage is a register with its own valid bit.
// A stage takes a new item when it is empty or its content moves on in the same cycle.
// Reset is synchronous and active low; it clears the valid bits only.
module heading_angle_degrees #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: first_x, first_y, second_x, second_y, zero fill.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0: heading, zero fill.
    output logic [23:0]                             m_axis_tdata
);
    import hdg_pkg::*;

    localparam int C      = COORD_WIDTH;
    localparam int W      = COORD_WIDTH + PRESCALE_BITS + 4;
    localparam int STAGES = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

    logic signed [C-1:0] first_x;
    logic signed [C-1:0] first_y;
    logic signed [C-1:0] second_x;
    logic signed [C-1:0] second_y;

    assign first_x  = s_axis_tdata[C-1:0];
    assign first_y  = s_axis_tdata[2*C-1:C];
    assign second_x = s_axis_tdata[3*C-1:2*C];
    assign second_y = s_axis_tdata[4*C-1:3*C];

    // Difference stage.
    logic                p0_v_reg;
    logic                p0_en;
    logic signed [C:0]   dx_reg;
    logic signed [C:0]   dz_reg;

    // Quadrant fold and prescale stage.
    logic                p1_v_reg;
    logic                p1_en;
    logic signed [W-1:0] xr_reg;
    logic signed [W-1:0] yr_reg;
    hdg_flags_t          p1_flags_reg;

    logic signed [C+1:0] dx_ext;
    logic signed [C+1:0] dz_ext;
    logic signed [C+1:0] dx_fold;
    logic signed [C+1:0] dz_fold;
    hdg_flags_t          p1_flags_next;

    // CORDIC chain.
    logic                    st_valid [STAGES+1];
    logic                    st_ready [STAGES+1];
    logic signed [W-1:0]     st_x     [STAGES+1];
    logic signed [W-1:0]     st_y     [STAGES+1];
    logic signed [ACC_W-1:0] st_acc   [STAGES+1];
    hdg_flags_t              st_flags [STAGES+1];

    // Output stages.
    logic                    f1_v_reg;
    logic                    f1_en;
    logic signed [ACC_W-1:0] f1_acc_reg;
    hdg_flags_t              f1_flags_reg;

    logic                    f2_v_reg;
    logic                    f2_en;
    logic signed [ACC_W-1:0] f2_acc_reg;
    logic signed [ACC_W-1:0] f2_acc_next;
    hdg_flags_t              f2_flags_reg;

    logic                    f3_v_reg;
    logic                    f3_en;
    logic [OUT_W-1:0]        heading_reg;
    logic [OUT_W-1:0]        heading_next;
    logic signed [ACC_W-1:0] round_sum;
    logic [OUT_W-1:0]        rounded;

    assign f3_en = !f3_v_reg || m_axis_tready;
    assign f2_en = !f2_v_reg || f3_en;
    assign f1_en = !f1_v_reg || f2_en;
    assign p1_en = !p1_v_reg || st_ready[0];
    assign p0_en = !p0_v_reg || p1_en;

    assign s_axis_tready = p0_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else begin
            if (p0_en) begin
                p0_v_reg <= s_axis_tvalid;
            end
            if (p1_en) begin
                p1_v_reg <= p0_v_reg;
            end
            if (f1_en) begin
                f1_v_reg <= st_valid[STAGES];
            end
            if (f2_en) begin
                f2_v_reg <= f1_v_reg;
            end
            if (f3_en) begin
                f3_v_reg <= f2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p0_en && s_axis_tvalid) begin
            dx_reg <= {first_x[C-1], first_x} - {second_x[C-1], second_x};
            dz_reg <= {first_y[C-1], first_y} - {second_y[C-1], second_y};
        end
    end

    always_comb begin
        dx_ext = {dx_reg[C], dx_reg};
        dz_ext = {dz_reg[C], dz_reg};
        p1_flags_next.zero_dx   = (dx_reg == '0);
        p1_flags_next.dz_pos    = !dz_reg[C] && (dz_reg != '0);
        p1_flags_next.left_half = dz_reg[C];
        if (dz_reg[C]) begin
            dx_fold = -dx_ext;
            dz_fold = -dz_ext;
        end else begin
            dx_fold = dx_ext;
            dz_fold = dz_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_en && p0_v_reg) begin
            xr_reg <= {{(W-PRESCALE_BITS-C-2){dz_fold[C+1]}}, dz_fold,
                       {PRESCALE_BITS{1'b0}}};
            yr_reg <= {{(W-PRESCALE_BITS-C-2){dx_fold[C+1]}}, dx_fold,
                       {PRESCALE_BITS{1'b0}}};
            p1_flags_reg <= p1_flags_next;
        end
    end

    assign st_valid[0] = p1_v_reg;
    assign st_x[0]     = xr_reg;
    assign st_y[0]     = yr_reg;
    assign st_acc[0]   = '0;
    assign st_flags[0] = p1_flags_reg;
    assign st_ready[STAGES] = f1_en;

    for (genvar k = 0; k < STAGES; k++) begin : g_cordic
        hdg_cordic_stage #(
            .W     (W),
            .SHIFT (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_x      (st_x[k]),
            .in_y      (st_y[k]),
            .in_acc    (st_acc[k]),
            .in_flags  (st_flags[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_x     (st_x[k+1]),
            .out_y     (st_y[k+1]),
            .out_acc   (st_acc[k+1]),
            .out_flags (st_flags[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (f1_en && st_valid[STAGES]) begin
            f1_acc_reg   <= st_acc[STAGES] + (st_flags[STAGES].left_half ? DEG180 : '0);
            f1_flags_reg <= st_flags[STAGES];
        end
    end

    always_comb begin
        if (f1_acc_reg < 0) begin
            f2_acc_next = f1_acc_reg + DEG360;
        end else if (f1_acc_reg >= DEG360) begin
            f2_acc_next = f1_acc_reg - DEG360;
        end else begin
            f2_acc_next = f1_acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f2_en && f1_v_reg) begin
            f2_acc_reg   <= f2_acc_next;
            f2_flags_reg <= f1_flags_reg;
        end
    end

    always_comb begin
        round_sum = f2_acc_reg + ROUND_HALF;
        rounded   = round_sum[ACC_W-2:8];
        if (f2_flags_reg.zero_dx) begin
            heading_next = f2_flags_reg.dz_pos ? ZERO_TURN_OUT : HALF_TURN_OUT;
        end else if (rounded >= FULL_TURN_OUT) begin
            heading_next = rounded - FULL_TURN_OUT;
        end else begin
            heading_next = rounded;
        end
    end

    always_ff @(posedge aclk) begin
        if (f3_en && f2_v_reg) begin
            heading_reg <= heading_next;
        end
    end

    assign m_axis_tvalid = f3_v_reg;
    assign m_axis_tdata  = {{(24-OUT_W){1'b0}}, heading_reg};

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:0] < FULL_TURN_OUT))
        else $error("heading out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        f2_v_reg |-> (f2_acc_reg >= 0 && f2_acc_reg < DEG360))
        else $error("wrapped angle out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && p0_v_reg))
        else $error("input stalled while pipeline can move");
`endif

endmodule

@@ dv/heading_checker.sv @@
`timescale 1ns / 1ps

module heading_checker #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // Fields from bit 0: first_x, first_y, second_x, second_y, zero fill.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: heading, zero fill.
    input  logic [23:0]                         m_axis_tdata,
    output int                                  fail_count,
    output int                                  pending
);

    import hdg_pkg::*;

    localparam int     DW        = ((4*COORD_WIDTH+7)/8)*8;
    localparam int     MAX_STAGE = 24;
    localparam int     SCALE_UP  = 20;
    localparam longint HALF_ACC  = 64'sd180 * 64'sd65536;
    localparam longint FULL_ACC  = 64'sd360 * 64'sd65536;
    localparam longint HALF_OUT  = 64'sd46080;
    localparam longint FULL_OUT  = 64'sd92160;

    // Arctangent of 2^-i in degrees, in units of 2^-16 degree.
    localparam longint ARCTAN_STEP [MAX_STAGE] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [OUT_W-1:0] headings_due [$];

    function automatic longint coord_at(input logic [DW-1:0] word, input int idx);
        longint v;
        v = longint'(word[idx*COORD_WIDTH +: COORD_WIDTH]);
        if (word[idx*COORD_WIDTH + COORD_WIDTH - 1])
            v = v - (64'sd1 <<< COORD_WIDTH);
        return v;
    endfunction

    function automatic logic [OUT_W-1:0] heading_of(input longint dx, input longint dz);
        longint xr, yr, nx, ny, acc, base, rounded;
        int     stages, i;
        if (dx == 0)
            return (dz > 0) ? OUT_W'(0) : OUT_W'(HALF_OUT);
        xr   = dz <<< SCALE_UP;
        yr   = dx <<< SCALE_UP;
        base = 0;
        if (xr < 0) begin
            xr   = -xr;
            yr   = -yr;
            base = HALF_ACC;
        end
        stages = (ITERATIONS > MAX_STAGE) ? MAX_STAGE : ITERATIONS;
        acc    = 0;
        for (i = 0; i < stages; i++) begin
            if (yr >= 0) begin
                nx  = xr + (yr >>> i);
                ny  = yr - (xr >>> i);
                acc = acc + ARCTAN_STEP[i];
            end else begin
                nx  = xr - (yr >>> i);
                ny  = yr + (xr >>> i);
                acc = acc - ARCTAN_STEP[i];
            end
            xr = nx;
            yr = ny;
        end
        acc = acc + base;
        if (acc < 0)
            acc = acc + FULL_ACC;
        if (acc >= FULL_ACC)
            acc = acc - FULL_ACC;
        if (acc < 0)
            acc = 0;
        rounded = (acc + 128) >>> 8;
        if (rounded >= FULL_OUT)
            rounded = rounded - FULL_OUT;
        return OUT_W'(rounded);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            headings_due.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                headings_due.push_back(heading_of(coord_at(s_axis_tdata, 0) -
                                                  coord_at(s_axis_tdata, 2),
                                                  coord_at(s_axis_tdata, 1) -
                                                  coord_at(s_axis_tdata, 3)));
            if (m_axis_tvalid && m_axis_tready) begin
                if (headings_due.size() == 0) begin
                    flag_mismatch("heading with no item waiting",
                                  longint'(m_axis_tdata), -64'sd1);
                end else begin
                    want = headings_due.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== want)
                        flag_mismatch("heading", longint'(m_axis_tdata[OUT_W-1:0]),
                                      longint'(want));
                    if (m_axis_tdata[23:OUT_W] !== '0)
                        flag_mismatch("zero fill", longint'(m_axis_tdata[23:OUT_W]),
                                      64'sd0);
                end
            end
            pending = headings_due.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int ITERATIONS     = 16;
    localparam int COORD_WIDTH    = 24;
    localparam int DW             = ((4*COORD_WIDTH+7)/8)*8;
    localparam int LATENCY        = ITERATIONS + 5;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int CALM_ITEMS     = 150;
    localparam int SQUEEZE_AT     = 300;
    localparam int SQUEEZE_CYCLES = 80;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t CNEG = '1;
    localparam coord_t CONE = 1;
    localparam coord_t CZER = '0;

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [23:0]   m_axis_tdata;

    int fail_count;
    int pending;
    bit calm         = 1'b0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    heading_angle_degrees #(
        .ITERATIONS (ITERATIONS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    heading_checker #(
        .ITERATIONS (ITERATIONS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // The receiver stalls in short random bursts and once for a long stretch.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeeze_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_points(input coord_t fx, input coord_t fy, input coord_t sx,
                               input coord_t sy);
        logic [DW-1:0] word;
        word = '0;
        word[0*COORD_WIDTH +: COORD_WIDTH] = fx;
        word[1*COORD_WIDTH +: COORD_WIDTH] = fy;
        word[2*COORD_WIDTH +: COORD_WIDTH] = sx;
        word[3*COORD_WIDTH +: COORD_WIDTH] = sy;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    function automatic coord_t edge_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return CZER;
            3: return CNEG;
            4: return CONE;
            default: return any_coord();
        endcase
    endfunction

    initial begin
        coord_t fx, fy, sx, sy;
        int     mag, n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero vector, then zero dx with dz on either side.
        send_points(CZER, CZER, CZER, CZER);
        send_points(CMAX, CMAX, CMAX, CMAX);
        send_points(CZER, CONE, CZER, CZER);
        send_points(CZER, CZER, CZER, CONE);
        send_points(CMIN, CMAX, CMIN, CMIN);
        send_points(CMAX, CMIN, CMAX, CMAX);
        // Largest differences along and across the axes.
        send_points(CMAX, CZER, CMIN, CZER);
        send_points(CMIN, CZER, CMAX, CZER);
        send_points(CMAX, CMIN, CMIN, CMAX);
        send_points(CMIN, CMIN, CMAX, CMAX);
        send_points(CMAX, CMAX, CMIN, CMIN);
        send_points(CMIN, CMAX, CMAX, CMIN);
        // Tiny angles next to north, which may round up to a full turn.
        send_points(CNEG, CMAX, CZER, CZER);
        send_points(CMIN, CMAX, CMIN + CONE, CMIN);
        send_points(CONE, CMAX, CZER, CZER);
        // Tiny angles on either side of south.
        send_points(CONE, CMIN, CZER, CZER);
        send_points(CNEG, CMIN, CZER, CZER);
        // The four diagonals.
        send_points(CONE, CONE, CZER, CZER);
        send_points(CONE, CNEG, CZER, CZER);
        send_points(CNEG, CNEG, CZER, CZER);
        send_points(CNEG, CONE, CZER, CZER);
        // Almost due east and almost due west.
        send_points(CMAX, CONE, CZER, CZER);
        send_points(CMIN, CNEG, CZER, CZER);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == SQUEEZE_AT)
                squeeze_req = 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            case ($urandom_range(0, 5))
                0: begin
                    fx = any_coord();
                    fy = any_coord();
                    sx = any_coord();
                    sy = any_coord();
                end
                1: begin
                    fx = any_coord();
                    fy = any_coord();
                    sx = fx - coord_t'($urandom_range(0, 32)) + coord_t'(16);
                    sy = fy - coord_t'($urandom_range(0, 32)) + coord_t'(16);
                end
                2: begin
                    fx = any_coord();
                    fy = any_coord();
                    sx = fx;
                    sy = any_coord();
                end
                3: begin
                    fx = any_coord();
                    fy = any_coord();
                    sx = any_coord();
                    sy = fy;
                end
                4: begin
                    mag = $urandom_range(1, int'(CMAX));
                    fx  = $urandom_range(0, 1) ? coord_t'(mag) : coord_t'(-mag);
                    fy  = $urandom_range(0, 1) ? coord_t'(mag) : coord_t'(-mag);
                    sx  = CZER;
                    sy  = CZER;
                end
                default: begin
                    fx = edge_coord();
                    fy = edge_coord();
                    sx = edge_coord();
                    sy = edge_coord();
                end
            endcase
            send_points(fx, fy, sx, sy);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/hdg_pkg.sv
rtl/hdg_cordic_stage.sv
rtl/heading_angle_degrees.sv
dv/heading_checker.sv
dv/tb_top.sv
